/* hdl/frpt_pkg.sv */
package frpt_pkg;

    localparam int NUM_ROBOTS   = 8;
    localparam int CORDIC_STEPS = 16;
    localparam int IDX_W        = (NUM_ROBOTS > 1) ? $clog2(NUM_ROBOTS) : 1;

    localparam logic signed [33:0] GAIN_Q30 = 34'sd652032874;

    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_XFORM = 1'b1;

    typedef logic signed [31:0] pos_t;
    typedef logic signed [15:0] ang_t;

    typedef struct packed {
        logic       mode;
        logic [2:0] robot;
        pos_t       obj_x;
        pos_t       obj_y;
        ang_t       obj_heading;
        pos_t       extension;
        ang_t       grasp_turn;
        pos_t       pt_x;
        pos_t       pt_y;
        pos_t       pt_z;
        ang_t       base_angle;
    } in_t;

    typedef struct packed {
        pos_t out_x;
        pos_t out_y;
        pos_t out_z;
        ang_t robot_heading;
    } out_t;

    // Arctangent of 2^-i as a fraction of a full turn, 32-bit.
    function automatic logic [31:0] atan_turn(input int i);
        logic [31:0] r;
        case (i)
            0:  r = 32'h20000000;
            1:  r = 32'h12E4051E;
            2:  r = 32'h09FB385B;
            3:  r = 32'h051111D4;
            4:  r = 32'h028B0D43;
            5:  r = 32'h0145D7E1;
            6:  r = 32'h00A2F61E;
            7:  r = 32'h00517C55;
            8:  r = 32'h0028BE53;
            9:  r = 32'h00145F2F;
            10: r = 32'h000A2F98;
            11: r = 32'h000517CC;
            12: r = 32'h00028BE6;
            13: r = 32'h000145F3;
            14: r = 32'h0000A2FA;
            15: r = 32'h0000517D;
            16: r = 32'h000028BE;
            17: r = 32'h0000145F;
            18: r = 32'h00000A30;
            19: r = 32'h00000518;
            20: r = 32'h0000028C;
            21: r = 32'h00000146;
            22: r = 32'h000000A3;
            23: r = 32'h00000051;
            default: r = 32'h0;
        endcase
        return r;
    endfunction

    // Round a Q16.16 x Q30 accumulation back to Q16.16 and wrap to 32 bits.
    function automatic pos_t rnd_q30(input logic signed [65:0] acc);
        logic signed [65:0] t;
        t = acc + 66'sd536870912;
        return t[61:30];
    endfunction

endpackage

/* hdl/frpt_sincos.sv */
module frpt_sincos (
    input  logic                 clk,
    input  logic                 en,
    input  frpt_pkg::ang_t       angle,
    output frpt_pkg::pos_t       cos_q30,
    output frpt_pkg::pos_t       sin_q30
);

    localparam int N = frpt_pkg::CORDIC_STEPS;

    logic signed [33:0] x_reg [0:N];
    logic signed [33:0] y_reg [0:N];
    logic signed [33:0] z_reg [0:N];
    logic               flip_reg [0:N];

    logic signed [31:0] u;
    logic               flip;
    logic signed [31:0] z0;

    always_comb
    begin
        u    = {angle, 16'h0000};
        flip = (u > 32'sh40000000) || (u < -32'sh40000000);
        z0   = flip ? (u + 32'sh80000000) : u;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0]    <= frpt_pkg::GAIN_Q30;
            y_reg[0]    <= '0;
            z_reg[0]    <= 34'(z0);
            flip_reg[0] <= flip;
        end
    end

    for (genvar i = 0; i < N; i++)
    begin : g_step
        logic signed [33:0] at;
        assign at = $signed({2'b00, frpt_pkg::atan_turn(i)});
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                flip_reg[i+1] <= flip_reg[i];
                if (z_reg[i] >= 0)
                begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - at;
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + at;
                end
            end
        end
    end

    assign cos_q30 = flip_reg[N] ? 32'(-x_reg[N]) : 32'(x_reg[N]);
    assign sin_q30 = flip_reg[N] ? 32'(-y_reg[N]) : 32'(y_reg[N]);

endmodule

/* hdl/frpt_bearing.sv */
module frpt_bearing (
    input  logic                 clk,
    input  logic                 en,
    input  frpt_pkg::pos_t       gx,
    input  frpt_pkg::pos_t       gy,
    output frpt_pkg::ang_t       bearing
);

    localparam int N = frpt_pkg::CORDIC_STEPS;

    logic signed [35:0] x_reg [0:N];
    logic signed [35:0] y_reg [0:N];
    logic        [31:0] z_reg [0:N];
    logic               zero_reg [0:N];

    logic               neg;
    logic        [31:0] zr;

    assign neg = gy < 0;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0]    <= neg ? -36'(gy) : 36'(gy);
            y_reg[0]    <= neg ? -36'(gx) : 36'(gx);
            z_reg[0]    <= neg ? 32'h80000000 : 32'h0;
            zero_reg[0] <= (gx == 0) && (gy == 0);
        end
    end

    // Angle is kept modulo a full turn; only its low 32 bits matter.
    for (genvar i = 0; i < N; i++)
    begin : g_step
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                zero_reg[i+1] <= zero_reg[i];
                if (y_reg[i] >= 0)
                begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + frpt_pkg::atan_turn(i);
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - frpt_pkg::atan_turn(i);
                end
            end
        end
    end

    assign zr      = z_reg[N] + 32'h00008000;
    assign bearing = zero_reg[N] ? 16'sh0000 : $signed(zr[31:16]);

endmodule

/* hdl/formation_robot_point_transform.sv */
// Throughput: one transaction per cycle; the pipeline advances whenever the output
// register is empty or being taken, and holds as a whole otherwise.
// Loads write the robot table at acceptance and produce no result.
// Reset (rst_n, asynchronous, active low) clears all valid bits; table and data
// registers are not reset.
module formation_robot_point_transform (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  frpt_pkg::in_t  in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output frpt_pkg::out_t out_data
);

    localparam int N = frpt_pkg::CORDIC_STEPS;

    typedef struct packed {
        frpt_pkg::ang_t heading;
        frpt_pkg::ang_t phi;
        frpt_pkg::ang_t b;
        frpt_pkg::pos_t d;
        frpt_pkg::pos_t gx;
        frpt_pkg::pos_t gy;
        frpt_pkg::pos_t oz;
        frpt_pkg::pos_t objx;
        frpt_pkg::pos_t objy;
        frpt_pkg::pos_t px;
        frpt_pkg::pos_t py;
    } side_t;

    typedef struct packed {
        frpt_pkg::ang_t hsum;
        frpt_pkg::pos_t d;
        frpt_pkg::pos_t gx;
        frpt_pkg::pos_t gy;
        frpt_pkg::pos_t oz;
        frpt_pkg::pos_t objx;
        frpt_pkg::pos_t objy;
        frpt_pkg::pos_t px;
        frpt_pkg::pos_t py;
        frpt_pkg::pos_t cb;
        frpt_pkg::pos_t sb;
        frpt_pkg::pos_t cp;
        frpt_pkg::pos_t sp;
        frpt_pkg::pos_t ch;
        frpt_pkg::pos_t sh;
    } mid_t;

    typedef struct packed {
        mid_t               m;
        frpt_pkg::pos_t     chh;
        frpt_pkg::pos_t     shh;
        logic signed [63:0] p1;
        logic signed [63:0] p2;
        logic signed [63:0] p3;
        logic signed [63:0] p4;
        logic signed [63:0] q1;
        logic signed [63:0] q2;
        logic signed [63:0] q3;
        logic signed [63:0] q4;
        frpt_pkg::pos_t     vx;
        frpt_pkg::pos_t     vy;
        frpt_pkg::pos_t     ax;
        frpt_pkg::pos_t     ay;
        frpt_pkg::pos_t     qx;
        frpt_pkg::pos_t     qy;
        frpt_pkg::pos_t     rx;
        frpt_pkg::pos_t     ry;
    } tail_t;

    // Robot table
    frpt_pkg::pos_t gx_tab_reg [0:frpt_pkg::NUM_ROBOTS-1];
    frpt_pkg::pos_t gy_tab_reg [0:frpt_pkg::NUM_ROBOTS-1];
    frpt_pkg::pos_t gz_tab_reg [0:frpt_pkg::NUM_ROBOTS-1];
    frpt_pkg::ang_t ba_tab_reg [0:frpt_pkg::NUM_ROBOTS-1];

    logic                      en;
    logic                      accept;
    logic                      in_range;
    logic [frpt_pkg::IDX_W-1:0] idx;

    side_t e_reg, e_next;
    logic  e_vld_reg;
    side_t s1_reg [0:N];
    logic  s1_vld_reg [0:N];
    mid_t  h_reg, h_next;
    logic  h_vld_reg;
    mid_t  s2_reg [0:N];
    logic  s2_vld_reg [0:N];
    tail_t t_reg [1:7];
    tail_t t_next [1:7];
    logic  t_vld_reg [1:7];
    frpt_pkg::out_t out_reg, out_next;
    logic  out_valid_reg;

    frpt_pkg::pos_t ch, sh, cp, sp, cb, sb, chh, shh;
    frpt_pkg::ang_t bearing;

    assign en       = !out_valid_reg || out_ready;
    assign in_ready = en;
    assign accept   = in_valid && en;
    assign in_range = 32'(in_data.robot) < frpt_pkg::NUM_ROBOTS;
    assign idx      = frpt_pkg::IDX_W'(in_data.robot);

    always_ff @(posedge clk)
    begin
        if (accept && in_range && (in_data.mode == frpt_pkg::MODE_LOAD))
        begin
            gx_tab_reg[idx] <= in_data.pt_x;
            gy_tab_reg[idx] <= in_data.pt_y;
            gz_tab_reg[idx] <= in_data.pt_z;
            ba_tab_reg[idx] <= in_data.base_angle;
        end
    end

    always_comb
    begin
        e_next.heading = in_data.obj_heading;
        e_next.phi     = in_data.grasp_turn;
        e_next.b       = ba_tab_reg[idx];
        e_next.d       = in_data.extension;
        e_next.gx      = gx_tab_reg[idx];
        e_next.gy      = gy_tab_reg[idx];
        e_next.oz      = gz_tab_reg[idx] + in_data.pt_z;
        e_next.objx    = in_data.obj_x;
        e_next.objy    = in_data.obj_y;
        e_next.px      = in_data.pt_x;
        e_next.py      = in_data.pt_y;
    end

    frpt_sincos u_sc_head (.clk(clk), .en(en), .angle(e_reg.heading),
                           .cos_q30(ch), .sin_q30(sh));
    frpt_sincos u_sc_phi  (.clk(clk), .en(en), .angle(e_reg.phi),
                           .cos_q30(cp), .sin_q30(sp));
    frpt_sincos u_sc_base (.clk(clk), .en(en), .angle(e_reg.b),
                           .cos_q30(cb), .sin_q30(sb));
    frpt_bearing u_bear   (.clk(clk), .en(en), .gx(e_reg.gx), .gy(e_reg.gy),
                           .bearing(bearing));

    always_comb
    begin
        h_next.hsum = 16'(s1_reg[N].heading + bearing + s1_reg[N].phi + s1_reg[N].b);
        h_next.d    = s1_reg[N].d;
        h_next.gx   = s1_reg[N].gx;
        h_next.gy   = s1_reg[N].gy;
        h_next.oz   = s1_reg[N].oz;
        h_next.objx = s1_reg[N].objx;
        h_next.objy = s1_reg[N].objy;
        h_next.px   = s1_reg[N].px;
        h_next.py   = s1_reg[N].py;
        h_next.cb   = cb;
        h_next.sb   = sb;
        h_next.cp   = cp;
        h_next.sp   = sp;
        h_next.ch   = ch;
        h_next.sh   = sh;
    end

    frpt_sincos u_sc_sum (.clk(clk), .en(en), .angle(h_reg.hsum),
                          .cos_q30(chh), .sin_q30(shh));

    always_comb
    begin
        // d (cos b, sin b)
        t_next[1]     = '0;
        t_next[1].m   = s2_reg[N];
        t_next[1].chh = chh;
        t_next[1].shh = shh;
        t_next[1].p1  = s2_reg[N].d * s2_reg[N].cb;
        t_next[1].p2  = s2_reg[N].d * s2_reg[N].sb;

        t_next[2]    = t_reg[1];
        t_next[2].vx = frpt_pkg::rnd_q30(66'(t_reg[1].p1));
        t_next[2].vy = frpt_pkg::rnd_q30(66'(t_reg[1].p2));

        // rotate by phi
        t_next[3]    = t_reg[2];
        t_next[3].p1 = t_reg[2].vx * t_reg[2].m.cp;
        t_next[3].p2 = t_reg[2].vy * t_reg[2].m.sp;
        t_next[3].p3 = t_reg[2].vx * t_reg[2].m.sp;
        t_next[3].p4 = t_reg[2].vy * t_reg[2].m.cp;

        t_next[4]    = t_reg[3];
        t_next[4].vx = frpt_pkg::rnd_q30(66'(t_reg[3].p1) - 66'(t_reg[3].p2));
        t_next[4].vy = frpt_pkg::rnd_q30(66'(t_reg[3].p3) + 66'(t_reg[3].p4));

        // add grasp; start point rotation by heading sum
        t_next[5]    = t_reg[4];
        t_next[5].ax = t_reg[4].m.gx + t_reg[4].vx;
        t_next[5].ay = t_reg[4].m.gy + t_reg[4].vy;
        t_next[5].q1 = t_reg[4].m.px * t_reg[4].chh;
        t_next[5].q2 = t_reg[4].m.py * t_reg[4].shh;
        t_next[5].q3 = t_reg[4].m.px * t_reg[4].shh;
        t_next[5].q4 = t_reg[4].m.py * t_reg[4].chh;

        // rotate by object heading
        t_next[6]    = t_reg[5];
        t_next[6].p1 = t_reg[5].ax * t_reg[5].m.ch;
        t_next[6].p2 = t_reg[5].ay * t_reg[5].m.sh;
        t_next[6].p3 = t_reg[5].ax * t_reg[5].m.sh;
        t_next[6].p4 = t_reg[5].ay * t_reg[5].m.ch;
        t_next[6].qx = frpt_pkg::rnd_q30(66'(t_reg[5].q1) - 66'(t_reg[5].q2));
        t_next[6].qy = frpt_pkg::rnd_q30(66'(t_reg[5].q3) + 66'(t_reg[5].q4));

        t_next[7]    = t_reg[6];
        t_next[7].rx = frpt_pkg::rnd_q30(66'(t_reg[6].p1) - 66'(t_reg[6].p2));
        t_next[7].ry = frpt_pkg::rnd_q30(66'(t_reg[6].p3) + 66'(t_reg[6].p4));

        out_next.out_x         = t_reg[7].m.objx + t_reg[7].rx + t_reg[7].qx;
        out_next.out_y         = t_reg[7].m.objy + t_reg[7].ry + t_reg[7].qy;
        out_next.out_z         = t_reg[7].m.oz;
        out_next.robot_heading = t_reg[7].m.hsum;
    end

    // Data registers: advance together on en, hold on stall.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            e_reg     <= e_next;
            s1_reg[0] <= e_reg;
            for (int i = 0; i < N; i++)
            begin
                s1_reg[i+1] <= s1_reg[i];
                s2_reg[i+1] <= s2_reg[i];
            end
            h_reg     <= h_next;
            s2_reg[0] <= h_reg;
            for (int k = 1; k <= 7; k++)
            begin
                t_reg[k] <= t_next[k];
            end
            out_reg   <= out_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e_vld_reg     <= 1'b0;
            h_vld_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i <= N; i++)
            begin
                s1_vld_reg[i] <= 1'b0;
                s2_vld_reg[i] <= 1'b0;
            end
            for (int k = 1; k <= 7; k++)
            begin
                t_vld_reg[k] <= 1'b0;
            end
        end
        else if (en)
        begin
            e_vld_reg     <= accept && in_range && (in_data.mode == frpt_pkg::MODE_XFORM);
            s1_vld_reg[0] <= e_vld_reg;
            for (int i = 0; i < N; i++)
            begin
                s1_vld_reg[i+1] <= s1_vld_reg[i];
                s2_vld_reg[i+1] <= s2_vld_reg[i];
            end
            h_vld_reg     <= s1_vld_reg[N];
            s2_vld_reg[0] <= h_vld_reg;
            t_vld_reg[1]  <= s2_vld_reg[N];
            for (int k = 1; k < 7; k++)
            begin
                t_vld_reg[k+1] <= t_vld_reg[k];
            end
            out_valid_reg <= t_vld_reg[7];
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    a_load_no_item: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (in_data.mode == frpt_pkg::MODE_LOAD)) |=> !e_vld_reg)
        else $error("load transaction entered the transform pipeline");

    a_xform_enters: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && in_range && (in_data.mode == frpt_pkg::MODE_XFORM)) |=> e_vld_reg)
        else $error("transform transaction dropped at entry");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (!en && t_vld_reg[7]) |=> t_vld_reg[7])
        else $error("tail stage lost an item during stall");

endmodule

/* tb/sv/formation_robot_point_transform_checker.sv */
module formation_robot_point_transform_checker (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  logic           in_ready,
    input  frpt_pkg::in_t  in_data,
    input  logic           out_valid,
    input  logic           out_ready,
    input  frpt_pkg::out_t out_data,
    output int             errors,
    output int             pending
);

    localparam longint GAIN = 652032874;

    longint unsigned atan_lut [0:23] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

    frpt_pkg::pos_t grasp_x [frpt_pkg::NUM_ROBOTS];
    frpt_pkg::pos_t grasp_y [frpt_pkg::NUM_ROBOTS];
    frpt_pkg::pos_t grasp_z [frpt_pkg::NUM_ROBOTS];
    logic [15:0]    bearing [frpt_pkg::NUM_ROBOTS];
    logic [15:0]    base_ang [frpt_pkg::NUM_ROBOTS];

    frpt_pkg::out_t expected_points [$];

    function automatic longint wrap32(input longint v);
        logic signed [31:0] t;
        t = v[31:0];
        return longint'(t);
    endfunction

    function automatic longint q30_round(input longint acc);
        return (acc + 64'sd536870912) >>> 30;
    endfunction

    function automatic void sin_cos(input logic [15:0] a, output longint c, output longint s);
        logic [31:0]        u;
        logic signed [31:0] zs;
        longint             x, y, z, dx, dy;
        bit                 flip;
        u = {a, 16'h0};
        zs = u;
        z = zs;
        flip = 0;
        x = GAIN;
        y = 0;
        if (z > 64'sh40000000 || z < -64'sh40000000)
        begin
            flip = 1;
            zs = u + 32'h80000000;
            z = zs;
        end
        for (int i = 0; i < frpt_pkg::CORDIC_STEPS && i < 24; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x -= dx; y += dy; z -= longint'(atan_lut[i]);
            end
            else
            begin
                x += dx; y -= dy; z += longint'(atan_lut[i]);
            end
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endfunction

    function automatic logic [15:0] bearing_of(input longint gx, input longint gy);
        longint      x, y, z, dx, dy;
        logic [31:0] zr;
        x = gy;
        y = gx;
        z = 0;
        // both zero: no direction, bearing stays zero
        if (x == 0 && y == 0)
            return 16'h0;
        if (x < 0)
        begin
            x = -x; y = -y; z = 64'sd2147483648;
        end
        for (int i = 0; i < frpt_pkg::CORDIC_STEPS && i < 24; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0)
            begin
                x += dx; y -= dy; z += longint'(atan_lut[i]);
            end
            else
            begin
                x -= dx; y += dy; z -= longint'(atan_lut[i]);
            end
        end
        zr = 32'(z + 64'sh8000);
        return zr[31:16];
    endfunction

    function automatic void rotate(input longint x, input longint y, input longint c,
                                   input longint s, output longint rx, output longint ry);
        rx = wrap32(q30_round(x * c - y * s));
        ry = wrap32(q30_round(x * s + y * c));
    endfunction

    function automatic frpt_pkg::out_t transform_point(input frpt_pkg::in_t t);
        frpt_pkg::out_t r;
        longint         ch, sh, cp, sp, cb, sb, chh, shh;
        longint         d, vx, vy, wx, wy, rx, ry, tx, ty, qx, qy, sx, sy;
        logic [15:0]    hsum;
        int             k;
        k = int'(t.robot);
        d = t.extension;
        sin_cos(t.obj_heading, ch, sh);
        sin_cos(t.grasp_turn, cp, sp);
        sin_cos(base_ang[k], cb, sb);
        vx = wrap32(q30_round(d * cb));
        vy = wrap32(q30_round(d * sb));
        rotate(vx, vy, cp, sp, wx, wy);
        rotate(wrap32(longint'(grasp_x[k]) + wx), wrap32(longint'(grasp_y[k]) + wy),
               ch, sh, rx, ry);
        tx = wrap32(longint'(t.obj_x) + rx);
        ty = wrap32(longint'(t.obj_y) + ry);
        hsum = t.obj_heading + bearing[k] + t.grasp_turn + base_ang[k];
        sin_cos(hsum, chh, shh);
        sx = t.pt_x;
        sy = t.pt_y;
        rotate(sx, sy, chh, shh, qx, qy);
        r.out_x = 32'(tx + qx);
        r.out_y = 32'(ty + qy);
        r.out_z = grasp_z[k] + t.pt_z;
        r.robot_heading = hsum;
        return r;
    endfunction

    assign pending = expected_points.size();

    always @(posedge clk or negedge rst_n)
    begin
        frpt_pkg::out_t want;
        if (!rst_n)
        begin
            errors <= 0;
            expected_points.delete();
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                if (in_data.robot < frpt_pkg::NUM_ROBOTS)
                begin
                    if (in_data.mode == frpt_pkg::MODE_LOAD)
                    begin
                        grasp_x[in_data.robot] = in_data.pt_x;
                        grasp_y[in_data.robot] = in_data.pt_y;
                        grasp_z[in_data.robot] = in_data.pt_z;
                        base_ang[in_data.robot] = in_data.base_angle;
                        bearing[in_data.robot] = bearing_of(longint'(in_data.pt_x),
                                                            longint'(in_data.pt_y));
                    end
                    else
                    begin
                        expected_points.push_back(transform_point(in_data));
                    end
                end
            end
            if (out_valid && out_ready)
            begin
                if (expected_points.size() == 0)
                begin
                    $display("%0t: unexpected transaction %h", $time, out_data);
                    errors <= errors + 1;
                end
                else
                begin
                    want = expected_points.pop_front();
                    if (want !== out_data)
                    begin
                        $display("%0t: mismatch x exp %h got %h, y exp %h got %h",
                                 $time, want.out_x, out_data.out_x,
                                 want.out_y, out_data.out_y);
                        $display("%0t: mismatch z exp %h got %h, heading exp %h got %h",
                                 $time, want.out_z, out_data.out_z,
                                 want.robot_heading, out_data.robot_heading);
                        errors <= errors + 1;
                    end
                end
            end
        end
    end

endmodule

/* tb/sv/formation_robot_point_transform_test.sv */
module formation_robot_point_transform_test;

    localparam int NUM_RANDOM = 1700;
    localparam int QUIET_TAIL = 200;
    localparam int CYCLE_LIMIT = 400000;

    logic           clk;
    logic           rst_n;
    logic           in_valid;
    logic           in_ready;
    frpt_pkg::in_t  in_data;
    logic           out_valid;
    logic           out_ready;
    frpt_pkg::out_t out_data;
    int             errors;
    int             pending;
    int             cycles;
    bit             quiet;
    int             stall_left;
    int             run_left;

    formation_robot_point_transform dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
    );

    formation_robot_point_transform_checker checker_i (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .errors(errors), .pending(pending)
    );

    initial
    begin
        clk = 0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // Receiver: random stall bursts, none in the tail.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            stall_left <= 0;
            run_left <= 5;
        end
        else if (quiet)
        begin
            out_ready <= 1'b1;
        end
        else if (stall_left > 0)
        begin
            out_ready <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if (run_left > 0)
        begin
            out_ready <= 1'b1;
            run_left <= run_left - 1;
        end
        else
        begin
            out_ready <= 1'b0;
            stall_left <= $urandom_range(10, 0);
            run_left <= ($urandom_range(3, 0) == 0) ? $urandom_range(60, 20)
                                                    : $urandom_range(12, 1);
        end
    end

    function automatic logic [31:0] rand_pos();
        case ($urandom_range(5, 0))
            0: return 32'h80000000;
            1: return 32'h7FFFFFFF;
            2: return $urandom_range(32'h0004_0000, 0) - 32'h0002_0000;
            default: return $urandom;
        endcase
    endfunction

    function automatic frpt_pkg::in_t make_load(input logic [2:0] r,
                                                input frpt_pkg::pos_t gx,
                                                input frpt_pkg::pos_t gy,
                                                input frpt_pkg::pos_t gz,
                                                input frpt_pkg::ang_t b);
        frpt_pkg::in_t t;
        t = '0;
        t.obj_x = $urandom;
        t.obj_y = $urandom;
        t.obj_heading = 16'($urandom);
        t.extension = $urandom;
        t.grasp_turn = 16'($urandom);
        t.mode = frpt_pkg::MODE_LOAD;
        t.robot = r;
        t.pt_x = gx;
        t.pt_y = gy;
        t.pt_z = gz;
        t.base_angle = b;
        return t;
    endfunction

    function automatic frpt_pkg::in_t make_xform(input logic [2:0] r,
                                                 input frpt_pkg::pos_t ox,
                                                 input frpt_pkg::pos_t oy,
                                                 input frpt_pkg::ang_t h,
                                                 input frpt_pkg::pos_t d,
                                                 input frpt_pkg::ang_t phi,
                                                 input frpt_pkg::pos_t px,
                                                 input frpt_pkg::pos_t py,
                                                 input frpt_pkg::pos_t pz);
        frpt_pkg::in_t t;
        t.mode = frpt_pkg::MODE_XFORM;
        t.robot = r;
        t.obj_x = ox;
        t.obj_y = oy;
        t.obj_heading = h;
        t.extension = d;
        t.grasp_turn = phi;
        t.pt_x = px;
        t.pt_y = py;
        t.pt_z = pz;
        t.base_angle = 16'($urandom);
        return t;
    endfunction

    // Hold valid and payload until the transaction is taken.
    task automatic send(input frpt_pkg::in_t t);
        int gap;
        if (!quiet && $urandom_range(2, 0) == 0)
        begin
            gap = $urandom_range(11, 1);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= t;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    initial
    begin
        frpt_pkg::in_t t;
        logic [2:0]    r;
        rst_n = 0;
        in_valid = 0;
        in_data = '0;
        out_ready = 0;
        cycles = 0;
        quiet = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // grasp at the origin, extreme grasp coordinates, negative gy
        send(make_load(3'd0, 0, 0, 0, 16'h0));
        send(make_load(3'd1, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 16'h7FFF));
        send(make_load(3'd2, 32'h80000000, 32'h80000000, 32'h80000000, 16'h8000));
        send(make_load(3'd3, 32'h0001_0000, -32'sh0002_0000, 32'h0000_8000, 16'h4000));
        send(make_load(3'd4, -32'sh0001_0000, 0, -32'sh1, 16'hC000));
        send(make_load(3'd5, 0, 32'h0003_0000, 32'h1234_5678, 16'h2000));
        send(make_load(3'd6, $urandom, $urandom, $urandom, 16'($urandom)));
        send(make_load(3'd7, 0, -32'sh0001_0000, $urandom, 16'hFFFF));

        send(make_xform(3'd0, 0, 0, 16'h0, 0, 16'h0, 0, 0, 0));
        send(make_xform(3'd1, 32'h7FFFFFFF, 32'h7FFFFFFF, 16'h7FFF, 32'h7FFFFFFF, 16'h7FFF,
                        32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF));
        send(make_xform(3'd2, 32'h80000000, 32'h80000000, 16'h8000, 32'h80000000, 16'h8000,
                        32'h80000000, 32'h80000000, 32'h80000000));
        send(make_xform(3'd3, 32'h0001_0000, 0, 16'h4000, 32'h0002_0000, 16'hC000,
                        32'h0001_0000, 0, 0));
        send(make_xform(3'd4, 0, 32'h0001_0000, 16'h4001, 32'h0001_0000, 16'h3FFF,
                        0, 32'h0001_0000, 32'hFFFFFFFF));
        send(make_xform(3'd5, -32'sh1, -32'sh1, 16'hBFFF, -32'sh0001_0000, 16'h0001,
                        -32'sh1, 1, 1));
        send(make_xform(3'd6, $urandom, $urandom, 16'($urandom), $urandom, 16'($urandom),
                        $urandom, $urandom, $urandom));
        send(make_xform(3'd7, 0, 0, 16'hFFFF, 32'h0000_8000, 16'h8001, 0, 0, 0));
        send(make_xform(3'd0, 32'h0010_0000, 0, 16'h2000, 0, 16'h0, 32'h7FFFFFFF, 0, 0));

        for (int n = 0; n < NUM_RANDOM; n++)
        begin
            if (n == NUM_RANDOM - QUIET_TAIL)
                quiet = 1;
            r = 3'($urandom_range(7, 0));
            if ($urandom_range(9, 0) == 0)
            begin
                send(make_load(r, rand_pos(), rand_pos(), rand_pos(), 16'($urandom)));
            end
            else
            begin
                t = make_xform(r, rand_pos(), rand_pos(), 16'($urandom), rand_pos(),
                               16'($urandom), rand_pos(), rand_pos(), rand_pos());
                send(t);
            end
        end
        in_valid <= 1'b0;
        quiet = 1;

        while (pending != 0) @(posedge clk);
        repeat (60) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
